[sv/mae_pkg.sv]
// Shared types and constants of the matrix arithmetic engine.
package mae_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int AW         = $clog2(DEPTH);
  localparam int IW         = $clog2(MAX_DIM);
  localparam int DW         = 4;
  localparam int FW         = AW + 1;
  localparam int ELEM_WIDTH = 32;
  localparam int CMD_DEPTH  = 4;
  localparam int ACC_W      = 2 * ELEM_WIDTH + 3;
  localparam int DIVD_W     = ELEM_WIDTH + 16;

  localparam logic [1:0] CFG_OP_MODE   = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT = 2'd1;
  localparam logic [1:0] CFG_COL_COUNT = 2'd2;
  localparam logic [1:0] CFG_SCALAR    = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MATMUL, OP_TRANSPOSE, OP_SADD, OP_SMUL, OP_SDIV, OP_MATVEC
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_DATA, S_EXEC, S_DIV, S_EMIT
  } state_t;

  typedef struct packed {
    logic                         kind;
    logic signed [ELEM_WIDTH-1:0] elem_value;
    logic                         load_last;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] result_value;
    logic [IW-1:0]                result_row;
    logic [IW-1:0]                result_col;
    logic                         overflow;
    logic                         last;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic                  kind;
    logic [AW-1:0]         addr;
    logic [ELEM_WIDTH-1:0] value;
    logic                  start;
  } cmd_t;

  typedef struct packed {
    op_t                          mode;
    logic [DW-1:0]                rows;
    logic [DW-1:0]                cols;
    logic signed [ELEM_WIDTH-1:0] scalar;
  } cfg_t;

endpackage

[sv/mae_front.sv]
// Front end: configuration registers, fill counts and command generation.
module mae_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_push,
  input  mae_pkg::in_item_t        in_item,
  output mae_pkg::cmd_t            cmd,
  output mae_pkg::cfg_t            cfg
);
  import mae_pkg::*;

  op_t                   op_r;
  logic [DW-1:0]         rows_r, cols_r;
  logic [ELEM_WIDTH-1:0] scalar_r;
  logic [FW-1:0]         a_fill_r, a_fill_nxt, b_fill_r, b_fill_nxt;
  logic [FW-1:0]         fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= OP_ADD;
      rows_r   <= DW'(MAX_DIM);
      cols_r   <= DW'(MAX_DIM);
      scalar_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OP_MODE:   op_r     <= op_t'(cfg_data[2:0]);
        CFG_ROW_COUNT: rows_r   <= cfg_data[DW-1:0];
        CFG_COL_COUNT: cols_r   <= cfg_data[DW-1:0];
        CFG_SCALAR:    scalar_r <= cfg_data[ELEM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
    if (d == '0) return DW'(1);
    if (d > DW'(MAX_DIM)) return DW'(MAX_DIM);
    return d;
  endfunction

  assign cfg.mode   = op_r;
  assign cfg.rows   = clamp_dim(rows_r);
  assign cfg.cols   = clamp_dim(cols_r);
  assign cfg.scalar = scalar_r;

  assign fill      = in_item.kind ? b_fill_r : a_fill_r;
  assign cmd.we    = (fill != FW'(DEPTH));
  assign cmd.kind  = in_item.kind;
  assign cmd.addr  = fill[AW-1:0];
  assign cmd.value = in_item.elem_value;
  assign cmd.start = in_item.load_last;

  always_comb begin
    a_fill_nxt = a_fill_r;
    b_fill_nxt = b_fill_r;
    if (in_push) begin
      if (in_item.load_last) begin
        a_fill_nxt = '0;
        b_fill_nxt = '0;
      end else if (cmd.we) begin
        if (in_item.kind) b_fill_nxt = b_fill_r + FW'(1);
        else a_fill_nxt = a_fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_fill_r <= '0;
      b_fill_r <= '0;
    end else begin
      a_fill_r <= a_fill_nxt;
      b_fill_r <= b_fill_nxt;
    end
  end

endmodule

[sv/mae_cmd_fifo.sv]
// Command queue between front end and execution back end.
module mae_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mae_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output mae_pkg::cmd_t rdata,
  output logic          empty
);
  import mae_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);

  cmd_t          mem [CMD_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + PW'(1);
      if (do_pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

[sv/mae_back.sv]
// Back end: operand stores, sequencer, multiply-accumulate, divider and result queue.
module mae_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mae_pkg::cfg_t      cfg,
  input  mae_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output mae_pkg::out_item_t out_item
);
  import mae_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (ELEM_WIDTH-1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];

  state_t                    state_r, state_nxt;
  logic [IW-1:0]             o_r, o_nxt, n_r, n_nxt, k_r, k_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, res_r, res_nxt;
  logic                      ovf_r, ovf_nxt;
  logic signed [2*ELEM_WIDTH-1:0] prod_r;
  logic [ELEM_WIDTH-1:0]     ra_r, rb_r;
  logic [DIVD_W-1:0]         dq_r, dq_nxt;
  logic [ELEM_WIDTH:0]       rem_r, rem_nxt;
  logic [ELEM_WIDTH-1:0]     dsor_r, dsor_nxt;
  logic                      dneg_r, dneg_nxt;
  logic [5:0]                dcnt_r, dcnt_nxt;

  logic [DW-1:0]             olim, ilim;
  logic                      last_o, last_n, last_k, is_tr, is_mv;
  logic [AW:0]               a_idx, b_idx;
  logic signed [ACC_W-1:0]   ra_s, rb_s, sc_s, prod_s, sum_s;
  logic [ELEM_WIDTH:0]       rem_sh;
  logic                      qbit;
  logic [DIVD_W-1:0]         dq_step;
  logic                      emit_go;

  out_item_t                 oq_mem [2];
  logic                      oq_wp_r, oq_rp_r;
  logic [1:0]                oq_cnt_r;
  logic                      oq_full;
  out_item_t                 emit_item;
  logic signed [ELEM_WIDTH-1:0] sat_val;
  logic                      sat_ovf;

  assign is_tr  = (cfg.mode == OP_TRANSPOSE);
  assign is_mv  = (cfg.mode == OP_MATVEC);
  assign olim   = is_tr ? cfg.cols : cfg.rows;
  assign ilim   = is_tr ? cfg.rows : (is_mv ? DW'(1) : cfg.cols);
  assign last_o = ({1'b0, o_r} + DW'(1)) == olim;
  assign last_n = ({1'b0, n_r} + DW'(1)) == ilim;
  assign last_k = ({1'b0, k_r} + DW'(1)) == cfg.cols;

  always_comb begin
    case (cfg.mode)
      OP_TRANSPOSE: a_idx = (AW+1)'(n_r) * (AW+1)'(cfg.cols) + (AW+1)'(o_r);
      OP_MATMUL, OP_MATVEC: a_idx = (AW+1)'(o_r) * (AW+1)'(cfg.cols) + (AW+1)'(k_r);
      default: a_idx = (AW+1)'(o_r) * (AW+1)'(cfg.cols) + (AW+1)'(n_r);
    endcase
    case (cfg.mode)
      OP_MATMUL: b_idx = (AW+1)'(k_r) * (AW+1)'(cfg.cols) + (AW+1)'(n_r);
      OP_MATVEC: b_idx = (AW+1)'(k_r);
      default: b_idx = (AW+1)'(o_r) * (AW+1)'(cfg.cols) + (AW+1)'(n_r);
    endcase
  end

  assign cmd_pop = (state_r == S_IDLE) && !cmd_empty;

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.we && !cmd.kind) a_mem[cmd.addr] <= cmd.value;
    if (cmd_pop && cmd.we && cmd.kind) b_mem[cmd.addr] <= cmd.value;
    if (state_r == S_ADDR) begin
      ra_r <= a_mem[a_idx[AW-1:0]];
      rb_r <= b_mem[b_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DATA) begin
      if (cfg.mode == OP_SMUL) prod_r <= $signed(ra_r) * cfg.scalar;
      else prod_r <= $signed(ra_r) * $signed(rb_r);
    end
  end

  assign ra_s   = ACC_W'($signed(ra_r));
  assign rb_s   = ACC_W'($signed(rb_r));
  assign sc_s   = ACC_W'(cfg.scalar);
  assign prod_s = ACC_W'(prod_r);
  assign sum_s  = acc_r + prod_s;

  assign rem_sh  = {rem_r[ELEM_WIDTH-1:0], dq_r[DIVD_W-1]};
  assign qbit    = (rem_sh >= {1'b0, dsor_r});
  assign dq_step = {dq_r[DIVD_W-2:0], qbit};

  assign emit_go = (state_r == S_EMIT) && !oq_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd_pop && cmd.start) state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_DATA;
      S_DATA: state_nxt = S_EXEC;
      S_EXEC: begin
        case (cfg.mode)
          OP_MATMUL, OP_MATVEC: state_nxt = last_k ? S_EMIT : S_ADDR;
          OP_SDIV: state_nxt = (cfg.scalar == '0) ? S_EMIT : S_DIV;
          default: state_nxt = S_EMIT;
        endcase
      end
      S_DIV: if (dcnt_r == 6'(DIVD_W - 1)) state_nxt = S_EMIT;
      S_EMIT: if (emit_go) state_nxt = (last_o && last_n) ? S_IDLE : S_ADDR;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    o_nxt    = o_r;
    n_nxt    = n_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    ovf_nxt  = ovf_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    dneg_nxt = dneg_r;
    dcnt_nxt = dcnt_r;
    case (state_r)
      S_IDLE: begin
        o_nxt   = '0;
        n_nxt   = '0;
        k_nxt   = '0;
        acc_nxt = '0;
      end
      S_EXEC: begin
        ovf_nxt = 1'b0;
        case (cfg.mode)
          OP_ADD:       res_nxt = ra_s + rb_s;
          OP_SUB:       res_nxt = ra_s - rb_s;
          OP_TRANSPOSE: res_nxt = ra_s;
          OP_SADD:      res_nxt = ra_s + sc_s;
          OP_SMUL:      res_nxt = prod_s >>> 16;
          OP_MATMUL, OP_MATVEC: begin
            if (last_k) begin
              res_nxt = sum_s >>> 16;
              acc_nxt = '0;
              k_nxt   = '0;
            end else begin
              acc_nxt = sum_s;
              k_nxt   = k_r + IW'(1);
            end
          end
          OP_SDIV: begin
            if (cfg.scalar == '0) begin
              res_nxt = ra_r[ELEM_WIDTH-1] ? SAT_LO - ACC_W'(1) : SAT_HI + ACC_W'(1);
              ovf_nxt = 1'b1;
            end else begin
              dq_nxt   = {(ra_r[ELEM_WIDTH-1] ? -ra_r : ra_r), 16'h0000};
              dsor_nxt = cfg.scalar[ELEM_WIDTH-1] ? -cfg.scalar : cfg.scalar;
              dneg_nxt = ra_r[ELEM_WIDTH-1] ^ cfg.scalar[ELEM_WIDTH-1];
              rem_nxt  = '0;
              dcnt_nxt = '0;
            end
          end
          default: res_nxt = ra_s;
        endcase
      end
      S_DIV: begin
        rem_nxt  = qbit ? rem_sh - {1'b0, dsor_r} : rem_sh;
        dq_nxt   = dq_step;
        dcnt_nxt = dcnt_r + 6'd1;
        res_nxt  = dneg_r ? -ACC_W'(dq_step) : ACC_W'(dq_step);
      end
      S_EMIT: begin
        if (emit_go) begin
          if (last_n) begin
            n_nxt = '0;
            o_nxt = o_r + IW'(1);
          end else begin
            n_nxt = n_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_r    <= o_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    ovf_r  <= ovf_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
    dneg_r <= dneg_nxt;
    dcnt_r <= dcnt_nxt;
  end

  always_comb begin
    sat_ovf = ovf_r;
    if (res_r > SAT_HI) begin
      sat_val = SAT_HI[ELEM_WIDTH-1:0];
      sat_ovf = 1'b1;
    end else if (res_r < SAT_LO) begin
      sat_val = SAT_LO[ELEM_WIDTH-1:0];
      sat_ovf = 1'b1;
    end else begin
      sat_val = res_r[ELEM_WIDTH-1:0];
    end
  end

  assign emit_item.result_value = sat_val;
  assign emit_item.result_row   = o_r;
  assign emit_item.result_col   = is_mv ? IW'(0) : n_r;
  assign emit_item.overflow     = sat_ovf;
  assign emit_item.last         = last_o && last_n;

  assign oq_full   = (oq_cnt_r == 2'd2);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_item  = oq_mem[oq_rp_r];

  always_ff @(posedge clk) begin
    if (emit_go) oq_mem[oq_wp_r] <= emit_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (emit_go) oq_wp_r <= ~oq_wp_r;
      if (out_pop && !out_empty) oq_rp_r <= ~oq_rp_r;
      oq_cnt_r <= oq_cnt_r + 2'(emit_go) - 2'(out_pop && !out_empty);
    end
  end

endmodule

[sv/matrix_arithmetic_engine.sv]
// Matrix arithmetic engine top level: front end, command queue and back end.
// Elements load at one per cycle, while the queue is not full, into a
// four-entry command queue; the back end writes each into the A or B store
// and, on the item marked load_last, runs the selected operation, emitting
// results in row-major order into a two-entry result queue. Add, subtract,
// transpose and scalar add/multiply step each element through address, data,
// execute and emit states; matrix and matrix-vector products repeat address,
// data and execute per column on the single shared multiply-accumulate unit;
// scalar divide: bit-serial divider, one quotient bit per cycle over 48 bits.
module matrix_arithmetic_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  mae_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output mae_pkg::out_item_t out_item
);
  import mae_pkg::*;

  cmd_t cmd_in, cmd_out;
  cfg_t cfg;
  logic cmd_empty, cmd_pop, in_take;

  assign in_take = push && !full;

  mae_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_take),
    .in_item   (in_item),
    .cmd       (cmd_in),
    .cfg       (cfg)
  );

  mae_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  mae_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_item  (out_item)
  );

endmodule
